>>> rtl/assert_macros.svh
// Assertion macros used by the core RTL file of the clock index.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ciga_pkg.sv
// ----------------------------------------------------------------------------
// ciga_pkg
// Types and constants shared by the clock index with ghost admission.
// ----------------------------------------------------------------------------
package ciga_pkg;
    localparam int Entries     = 16;
    localparam int GhostFactor = 8;
    localparam int GhostSlots  = Entries * GhostFactor;
    localparam int SlotW       = $clog2(Entries);
    localparam int GhostW      = $clog2(GhostSlots);
    localparam int CountW      = $clog2(Entries + 1);
    localparam int FillW       = $clog2(GhostSlots + 1);
    localparam int IdW         = 32;
    localparam int HitsW       = 8;
    localparam int DrawW       = 64;
    localparam logic [DrawW-1:0] AdmitReset = 64'd184467440737095516;
    localparam logic [HitsW-1:0] HitsMax = 8'd255;

    localparam logic [1:0] ModeInsert = 2'd0;
    localparam logic [1:0] ModeFind   = 2'd1;
    localparam logic [1:0] ModeFlush  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GH_RD,      // ghost scan: read issued
        S_GH_CHK,     // ghost scan: compare
        S_FIND_RD,
        S_FIND_CHK,
        S_SWP_RD,
        S_SWP_CHK,
        S_FL_RD,
        S_FL_OUT,
        S_DONE
    } t_state;
endpackage

>>> rtl/ciga_ram.sv
// ----------------------------------------------------------------------------
// ciga_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module ciga_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/clock_index_with_ghost_admission_core.sv
// ----------------------------------------------------------------------------
// clock_index_with_ghost_admission_core
// Clock replacement index of ids with hit counters and a ghost ring admission.
// ----------------------------------------------------------------------------
// Usage: pulse i_start with i_mode, i_entry_id and i_random_draw while o_busy
// is low; that cycle accepts the transaction. Results come back on o_ok,
// o_victim_valid, o_out_id, o_out_hits and o_last, each valid for exactly one
// cycle while o_strobe is high. The receiver cannot stall; every result must
// be taken in the cycle it appears. Insert, find and unknown modes give one
// result, flush gives Entries results with o_last on the final one.
// An insert that is not refused walks the whole ghost ring, then, when the
// index is full, the clock sweep over the slots. A find walks the used
// slots until a match, a flush walks every slot. Each walk reads one memory
// entry per step, a read state then a check state, and the registered read
// of the memories sets that pace. A refused insert, a find on an empty
// index and an unknown mode answer in the cycle after acceptance. o_busy
// drops in the cycle after the last result, so one transaction is finished
// before the next is taken.
// Reset (synchronous, active low) empties the index, the ghost valid bits
// and the counters, and restores the admission threshold. Ghost ids are not
// cleared: only slots with their valid bit set are ever compared.
// i_cfg_we writes the admission threshold; do so only while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module clock_index_with_ghost_admission_core
    import ciga_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [DrawW-1:0] i_cfg_wdata,
    input  logic             i_start,
    output logic             o_busy,
    input  logic [1:0]       i_mode,
    input  logic [IdW-1:0]   i_entry_id,
    input  logic [DrawW-1:0] i_random_draw,
    output logic             o_strobe,
    output logic             o_ok,
    output logic             o_victim_valid,
    output logic [IdW-1:0]   o_out_id,
    output logic [HitsW-1:0] o_out_hits,
    output logic             o_last
);
    // Control registers.
    t_state            r_state, n_state;
    logic [DrawW-1:0]  r_thresh;
    logic [IdW-1:0]    r_id;
    logic [DrawW-1:0]  r_draw;
    logic [CountW-1:0] r_used, n_used;
    logic [CountW-1:0] r_hitcnt, n_hitcnt;
    logic [SlotW-1:0]  r_hand, n_hand;
    logic [GhostW-1:0] r_gwp, n_gwp;
    logic [FillW-1:0]  r_gfill, n_gfill;
    logic [GhostSlots-1:0] r_glive, n_glive;
    logic [GhostW-1:0] r_gidx, n_gidx;
    logic              r_gfound, n_gfound;
    logic [CountW-1:0] r_sidx, n_sidx;   // slot walk index / step count
    logic [CountW-1:0] r_nsw, n_nsw;     // sweep steps taken

    // Memories.
    logic             slot_we;
    logic [SlotW-1:0] slot_waddr, slot_raddr;
    logic [IdW-1:0]   slot_wid, slot_rid;
    logic [HitsW-1:0] slot_whits, slot_rhits;
    logic             gh_we;
    logic [IdW-1:0]   gh_rid;

    ciga_ram #(.Width(IdW), .Depth(Entries)) u_ids (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_wid),
        .i_raddr(slot_raddr), .o_rdata(slot_rid));
    ciga_ram #(.Width(HitsW), .Depth(Entries)) u_hits (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_whits),
        .i_raddr(slot_raddr), .o_rdata(slot_rhits));
    ciga_ram #(.Width(IdW), .Depth(GhostSlots)) u_ghost (
        .i_clk(i_clk), .i_we(gh_we), .i_waddr(r_gwp), .i_wdata(slot_rid),
        .i_raddr(r_gidx), .o_rdata(gh_rid));

    // Slots that were never written must read as zero, as they do after
    // reset. Slot contents are kept across a flush, so a written-once vector
    // masks the memory read data instead of a clearing pass.
    logic [Entries-1:0] r_written, n_written;

    logic full, all_hit, admit_hit;
    logic [SlotW-1:0] sidx_lo;
    assign full     = (r_used == CountW'(Entries));
    assign all_hit  = (r_hitcnt == CountW'(Entries));
    assign admit_hit = r_gfound || (r_gfill == '0) || (r_draw <= r_thresh);
    assign sidx_lo  = r_sidx[SlotW-1:0];

    logic [SlotW-1:0] slot_raddr_q;
    logic [IdW-1:0]   rd_id;
    logic [HitsW-1:0] rd_hits;
    assign rd_id   = r_written[slot_raddr_q] ? slot_rid : '0;
    assign rd_hits = r_written[slot_raddr_q] ? slot_rhits : '0;

    always_ff @(posedge i_clk) begin
        slot_raddr_q <= slot_raddr;
    end

    assign o_busy = (r_state != S_IDLE);

    // Next state and state updates.
    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_hitcnt  = r_hitcnt;
        n_hand    = r_hand;
        n_gwp     = r_gwp;
        n_gfill   = r_gfill;
        n_glive   = r_glive;
        n_gidx    = r_gidx;
        n_gfound  = r_gfound;
        n_sidx    = r_sidx;
        n_nsw     = r_nsw;
        n_written = r_written;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_sidx   = '0;
                    n_gidx   = '0;
                    n_gfound = 1'b0;
                    n_nsw    = '0;
                    case (i_mode)
                        ModeInsert: begin
                            if (full && all_hit) n_state = S_DONE;
                            else n_state = S_GH_RD;
                        end
                        ModeFind:  n_state = (r_used == '0) ? S_DONE : S_FIND_RD;
                        ModeFlush: n_state = S_FL_RD;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_GH_RD: n_state = S_GH_CHK;
            S_GH_CHK: begin
                if (r_glive[r_gidx] && gh_rid == r_id) begin
                    n_glive[r_gidx] = 1'b0;
                    n_gfound = 1'b1;
                end
                n_gidx = r_gidx + 1'b1;
                if (r_gidx == GhostW'(GhostSlots - 1)) begin
                    if (!full) begin
                        n_used = r_used + 1'b1;
                        n_written[r_used[SlotW-1:0]] = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SWP_RD;
                    end
                end else begin
                    n_state = S_GH_RD;
                end
            end
            S_FIND_RD: n_state = S_FIND_CHK;
            S_FIND_CHK: begin
                n_sidx = r_sidx + 1'b1;
                if (rd_id == r_id) begin
                    if (rd_hits == 8'd0) n_hitcnt = r_hitcnt + 1'b1;
                    n_state = S_DONE;
                end else if (n_sidx == r_used) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_FIND_RD;
                end
            end
            S_SWP_RD: n_state = S_SWP_CHK;
            S_SWP_CHK: begin
                n_hand = r_hand + 1'b1;
                n_nsw  = r_nsw + 1'b1;
                if (rd_hits == 8'd0) begin
                    n_gwp = r_gwp + 1'b1;
                    n_glive[r_gwp] = 1'b1;
                    if (r_gfill != FillW'(GhostSlots)) n_gfill = r_gfill + 1'b1;
                    n_state = S_DONE;
                end else if (n_nsw == CountW'(Entries)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SWP_RD;
                end
            end
            S_FL_RD: n_state = S_FL_OUT;
            S_FL_OUT: begin
                n_sidx = r_sidx + 1'b1;
                if (r_sidx == CountW'(Entries - 1)) begin
                    n_used   = '0;
                    n_hitcnt = '0;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_FL_RD;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_GH_CHK && r_gidx == GhostW'(GhostSlots - 1) && !full
                && (admit_hit || (r_glive[r_gidx] && gh_rid == r_id))) begin
            n_hitcnt = r_hitcnt + 1'b1;
        end
        if (r_state == S_SWP_CHK && rd_hits == 8'd0 && admit_hit) begin
            n_hitcnt = r_hitcnt + 1'b1;
        end
    end

    // Memory control and result outputs.
    logic last_hit;
    assign last_hit = admit_hit || (r_glive[r_gidx] && gh_rid == r_id);

    logic             r_res_ok, n_res_ok;
    logic             r_res_vv, n_res_vv;
    logic [IdW-1:0]   r_res_id, n_res_id;

    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = r_used[SlotW-1:0];
        slot_wid   = r_id;
        slot_whits = '0;
        slot_raddr = sidx_lo;
        gh_we      = 1'b0;
        n_res_ok   = r_res_ok;
        n_res_vv   = r_res_vv;
        n_res_id   = r_res_id;
        o_strobe       = 1'b0;
        o_ok           = 1'b0;
        o_victim_valid = 1'b0;
        o_out_id       = '0;
        o_out_hits     = '0;
        o_last         = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_res_ok = 1'b0;
                n_res_vv = 1'b0;
                n_res_id = '0;
            end
            S_GH_CHK: begin
                if (r_gidx == GhostW'(GhostSlots - 1) && !full) begin
                    slot_we    = 1'b1;
                    slot_whits = {{(HitsW-1){1'b0}}, last_hit};
                    n_res_ok   = 1'b1;
                end
                slot_raddr = r_hand;
            end
            S_FIND_CHK: begin
                if (rd_id == r_id) begin
                    n_res_ok = 1'b1;
                    if (rd_hits != HitsMax) begin
                        slot_we    = 1'b1;
                        slot_waddr = slot_raddr_q;
                        slot_wid   = rd_id;
                        slot_whits = rd_hits + 1'b1;
                    end
                end
            end
            S_SWP_RD: slot_raddr = r_hand;
            S_SWP_CHK: begin
                slot_raddr = n_hand;
                if (rd_hits == 8'd0) begin
                    gh_we      = 1'b1;
                    slot_we    = 1'b1;
                    slot_waddr = slot_raddr_q;
                    slot_whits = {{(HitsW-1){1'b0}}, admit_hit};
                    n_res_ok   = 1'b1;
                    n_res_vv   = 1'b1;
                    n_res_id   = rd_id;
                end
            end
            S_FL_OUT: begin
                o_strobe       = 1'b1;
                o_ok           = 1'b1;
                o_victim_valid = (r_sidx < r_used);
                o_out_id       = rd_id;
                o_out_hits     = rd_hits;
                o_last         = (r_sidx == CountW'(Entries - 1));
            end
            S_DONE: begin
                o_strobe       = 1'b1;
                o_ok           = r_res_ok;
                o_victim_valid = r_res_vv;
                o_out_id       = r_res_id;
                o_last         = 1'b1;
            end
            default: ;
        endcase
    end

    // The ghost write takes the victim id straight from the slot read data.
    // The sweep only runs on a full index, so every slot has been written
    // and the raw read data is exact.

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_thresh  <= AdmitReset;
            r_used    <= '0;
            r_hitcnt  <= '0;
            r_hand    <= '0;
            r_gwp     <= '0;
            r_gfill   <= '0;
            r_glive   <= '0;
            r_gidx    <= '0;
            r_gfound  <= 1'b0;
            r_sidx    <= '0;
            r_nsw     <= '0;
            r_written <= '0;
            r_res_ok  <= 1'b0;
            r_res_vv  <= 1'b0;
            r_res_id  <= '0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_hitcnt  <= n_hitcnt;
            r_hand    <= n_hand;
            r_gwp     <= n_gwp;
            r_gfill   <= n_gfill;
            r_glive   <= n_glive;
            r_gidx    <= n_gidx;
            r_gfound  <= n_gfound;
            r_sidx    <= n_sidx;
            r_nsw     <= n_nsw;
            r_written <= n_written;
            r_res_ok  <= n_res_ok;
            r_res_vv  <= n_res_vv;
            r_res_id  <= n_res_id;
            if (i_cfg_we) r_thresh <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_id   <= i_entry_id;
            r_draw <= i_random_draw;
        end
    end

    `ASSERT_IMPLY(a_used_range, i_clk, i_rst_n, 1'b1, r_used <= CountW'(Entries), "used overflow")
    `ASSERT_IMPLY(a_hit_le_used, i_clk, i_rst_n, r_state == S_IDLE, r_hitcnt <= r_used, "hits > used")
    `ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, r_state == S_DONE, r_state == S_IDLE && !o_strobe, "double result")
    `ASSERT_IMPLY(a_busy_strobe, i_clk, i_rst_n, o_strobe, o_busy, "strobe while idle")
endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the clock index with ghost admission. A
// transaction-level model in the bench predicts every result and the checker
// compares each strobed result, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tb
    import ciga_pkg::*;
();

    // Mode 3 has no name in the package; it is the "do nothing" command.
    localparam logic [1:0] ModeNone = 2'd3;
    localparam int TimeoutCycles = 1000000;

    typedef struct packed {
        logic             ok;
        logic             victim_valid;
        logic [IdW-1:0]   out_id;
        logic [HitsW-1:0] out_hits;
        logic             last;
    } t_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [DrawW-1:0] i_cfg_wdata;
    logic             i_start;
    logic             o_busy;
    logic [1:0]       i_mode;
    logic [IdW-1:0]   i_entry_id;
    logic [DrawW-1:0] i_random_draw;
    logic             o_strobe;
    logic             o_ok;
    logic             o_victim_valid;
    logic [IdW-1:0]   o_out_id;
    logic [HitsW-1:0] o_out_hits;
    logic             o_last;

    clock_index_with_ghost_admission_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_mode         (i_mode),
        .i_entry_id     (i_entry_id),
        .i_random_draw  (i_random_draw),
        .o_strobe       (o_strobe),
        .o_ok           (o_ok),
        .o_victim_valid (o_victim_valid),
        .o_out_id       (o_out_id),
        .o_out_hits     (o_out_hits),
        .o_last         (o_last)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // ------------------------------------------------------------------------
    // Shadow copy of the index. It mirrors the state of the block and is
    // advanced at the edge where each transaction is accepted, so the queue
    // of pending results always holds exactly what the block still owes us.
    // ------------------------------------------------------------------------
    logic [DrawW-1:0] threshold_q;
    logic [IdW-1:0]   slot_id_q   [Entries];
    logic [HitsW-1:0] slot_hits_q [Entries];
    int               used_q;
    int               hit_slots_q;
    int               hand_q;
    logic [IdW-1:0]   ghost_id_q  [GhostSlots];
    logic             ghost_live_q[GhostSlots];
    int               ghost_wr_q;
    int               ghost_fill_q;

    t_result pending_results[$];
    int      errors = 0;
    int      cycles = 0;

    function automatic t_result mk(logic ok, logic vv, logic [IdW-1:0] id,
                                   logic [HitsW-1:0] hits, logic last);
        t_result r;
        r.ok           = ok;
        r.victim_valid = vv;
        r.out_id       = id;
        r.out_hits     = hits;
        r.last         = last;
        return r;
    endfunction

    // Appends one predicted result at the tail of the pending queue.
    function automatic void owe_result(t_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Removes every live ghost copy of the id; returns whether any existed.
    function automatic logic ghost_claim(logic [IdW-1:0] id);
        logic found;
        found = 1'b0;
        for (int g = 0; g < GhostSlots; g++) begin
            if (ghost_live_q[g] && ghost_id_q[g] == id) begin
                ghost_live_q[g] = 1'b0;
                found = 1'b1;
            end
        end
        return found;
    endfunction

    function automatic void index_insert(logic [IdW-1:0] id, logic [DrawW-1:0] draw);
        logic admit;
        int   s;
        if (used_q >= Entries && hit_slots_q >= Entries) begin
            owe_result(mk(1'b0, 1'b0, '0, '0, 1'b1));
            return;
        end
        // The ghost claim must run first: it clears matches even when a
        // later term would have admitted the id anyway.
        admit = ghost_claim(id);
        admit = admit || ghost_fill_q == 0 || draw <= threshold_q;
        if (used_q < Entries) begin
            slot_id_q[used_q]   = id;
            slot_hits_q[used_q] = HitsW'(admit);
            used_q++;
            if (admit) hit_slots_q++;
            owe_result(mk(1'b1, 1'b0, '0, '0, 1'b1));
            return;
        end
        for (int n = 0; n < Entries; n++) begin
            s = hand_q;
            hand_q = (s + 1 >= Entries) ? 0 : s + 1;
            if (slot_hits_q[s] == 0) begin
                owe_result(mk(1'b1, 1'b1, slot_id_q[s], '0, 1'b1));
                ghost_id_q[ghost_wr_q]   = slot_id_q[s];
                ghost_live_q[ghost_wr_q] = 1'b1;
                ghost_wr_q = (ghost_wr_q + 1 >= GhostSlots) ? 0 : ghost_wr_q + 1;
                if (ghost_fill_q < GhostSlots) ghost_fill_q++;
                slot_id_q[s]   = id;
                slot_hits_q[s] = HitsW'(admit);
                if (admit) hit_slots_q++;
                return;
            end
        end
        owe_result(mk(1'b0, 1'b0, '0, '0, 1'b1));
    endfunction

    function automatic void index_find(logic [IdW-1:0] id);
        for (int s = 0; s < used_q; s++) begin
            if (slot_id_q[s] == id) begin
                // A counter at its ceiling stays there but still reports a hit.
                if (slot_hits_q[s] != HitsMax) begin
                    slot_hits_q[s]++;
                    if (slot_hits_q[s] == 1) hit_slots_q++;
                end
                owe_result(mk(1'b1, 1'b0, '0, '0, 1'b1));
                return;
            end
        end
        owe_result(mk(1'b0, 1'b0, '0, '0, 1'b1));
    endfunction

    function automatic void predict_index(logic [1:0] mode, logic [IdW-1:0] id,
                                          logic [DrawW-1:0] draw);
        case (mode)
            ModeInsert: index_insert(id, draw);
            ModeFind:   index_find(id);
            ModeFlush: begin
                // Flush reports every slot; contents stay, only the counts clear.
                for (int s = 0; s < Entries; s++)
                    owe_result(mk(1'b1, s < used_q, slot_id_q[s],
                                  slot_hits_q[s], s == Entries - 1));
                used_q      = 0;
                hit_slots_q = 0;
            end
            default: owe_result(mk(1'b0, 1'b0, '0, '0, 1'b1));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checker. The receiver cannot stall, so every strobe is one
    // accepted result and must match the oldest pending prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_strobe) begin
            got = mk(o_ok, o_victim_valid, o_out_id, o_out_hits, o_last);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.ok !== want.ok) begin
                    $display("%0t: ok expected %b actual %b", $time, want.ok, got.ok);
                    errors++;
                end
                if (got.victim_valid !== want.victim_valid) begin
                    $display("%0t: victim_valid expected %b actual %b", $time,
                             want.victim_valid, got.victim_valid);
                    errors++;
                end
                if (got.out_id !== want.out_id) begin
                    $display("%0t: out_id expected %h actual %h", $time,
                             want.out_id, got.out_id);
                    errors++;
                end
                if (got.out_hits !== want.out_hits) begin
                    $display("%0t: out_hits expected %0d actual %0d", $time,
                             want.out_hits, got.out_hits);
                    errors++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > TimeoutCycles) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Sends one transaction after a random gap. With no gap, i_start simply
    // stays high from the previous transaction, so it is never dropped and
    // raised again in one time step.
    task automatic send_command(logic [1:0] mode, logic [IdW-1:0] id,
                                logic [DrawW-1:0] draw);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_mode        <= mode;
        i_entry_id    <= id;
        i_random_draw <= draw;
        do @(posedge i_clk); while (o_busy);
        predict_index(mode, id, draw);
    endtask

    // Lets every owed result arrive and the block go idle.
    task automatic wait_idle();
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (o_busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [DrawW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        threshold_q = value;
    endtask

    function automatic logic [DrawW-1:0] any_draw();
        return {$urandom, $urandom};
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Fills the index with extreme ids, checks the refused insert on a full
    // index where every slot is hit, find hit and miss, flush and mode 3.
    task automatic test_fill_and_refuse();
        send_command(ModeInsert, 32'h0000_0000, 64'h0);
        send_command(ModeInsert, 32'hFFFF_FFFF, '1);
        for (int k = 2; k < Entries; k++)
            send_command(ModeInsert, 32'h1 << (k * 2), any_draw());
        send_command(ModeInsert, 32'hAAAA_5555, '1);
        send_command(ModeFind, 32'hFFFF_FFFF, '0);
        send_command(ModeFind, 32'h1234_5678, '1);
        send_command(ModeNone, 32'hFFFF_FFFF, '1);
        send_command(ModeFlush, '0, '0);
        send_command(ModeFind, 32'h0000_0000, '0);
    endtask

    // Drives one counter up to its ceiling and past it.
    task automatic test_hit_saturation();
        send_command(ModeInsert, 32'h5A5A_A5A5, any_draw());
        for (int k = 0; k < 257; k++)
            send_command(ModeFind, 32'h5A5A_A5A5, any_draw());
        send_command(ModeFlush, '0, '0);
    endtask

    // Random traffic over a small id pool so finds hit and the index keeps
    // filling, with occasional flushes to start a new round.
    task automatic test_random_traffic(int count);
        int               pick;
        logic [1:0]       mode;
        logic [IdW-1:0]   id;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)      mode = ModeInsert;
            else if (pick < 92) mode = ModeFind;
            else if (pick < 97) mode = ModeFlush;
            else                mode = ModeNone;
            id = ($urandom_range(0, 7) == 0) ? $urandom : IdW'($urandom_range(0, 23));
            send_command(mode, id, any_draw());
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        i_start       <= 1'b0;
        i_mode        <= ModeInsert;
        i_entry_id    <= '0;
        i_random_draw <= '0;
        threshold_q   = AdmitReset;
        for (int s = 0; s < Entries; s++) begin
            slot_id_q[s]   = '0;
            slot_hits_q[s] = '0;
        end
        for (int g = 0; g < GhostSlots; g++) begin
            ghost_id_q[g]   = '0;
            ghost_live_q[g] = 1'b0;
        end
        used_q       = 0;
        hit_slots_q  = 0;
        hand_q       = 0;
        ghost_wr_q   = 0;
        ghost_fill_q = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // First phase runs with the reset threshold.
        test_fill_and_refuse();
        wait_idle();
        write_threshold('0);
        test_hit_saturation();
        wait_idle();
        write_threshold('1);
        test_random_traffic(47);
        wait_idle();
        write_threshold(any_draw());
        test_random_traffic(47);
        wait_idle();
        write_threshold(AdmitReset);
        test_random_traffic(47);
        wait_idle();

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
